>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define OBFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define OBFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/obfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package obfp_pkg;

    localparam int MAX_BLOCKS_DEF = 8;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [15:0] START_WORD_RST  = 16'hAA55;
    localparam logic [15:0] RESYNC_WORD_RST = 16'h55AA;

    localparam logic [2:0] EV_SYNC       = 3'd0;
    localparam logic [2:0] EV_BLOCK_OK   = 3'd1;
    localparam logic [2:0] EV_CHECK_ERR  = 3'd2;
    localparam logic [2:0] EV_NO_DATA    = 3'd3;
    localparam logic [2:0] EV_STREAM_END = 3'd4;
    localparam logic [2:0] EV_NEW_FRAME  = 3'd5;

    localparam logic REG_START  = 1'b0;
    localparam logic REG_RESYNC = 1'b1;

    typedef enum logic [2:0] {
        OP_FIELD,
        OP_SYNC,
        OP_FRAME,
        OP_NO_DATA,
        OP_CHECK_ERR,
        OP_BLOCK,
        OP_END,
        OP_ADVANCE
    } obfp_op_t;

    typedef struct packed {
        obfp_op_t    op;
        logic [1:0]  slot;
        logic [15:0] word;
    } obfp_cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/obfp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface obfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/obfp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface obfp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [2:0]  block_index;
    logic [3:0]  block_count;
    logic [15:0] signature;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [15:0] obj_width;
    logic [15:0] obj_height;

    modport source (output valid, output event_res, output block_index, output block_count,
                    output signature, output x_pos, output y_pos, output obj_width,
                    output obj_height, input ready);
    modport sink (input valid, input event_res, input block_index, input block_count,
                  input signature, input x_pos, input y_pos, input obj_width,
                  input obj_height, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/obfp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module obfp_front
    import obfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    obfp_in_if.sink          in_ch,
    input  wire logic [15:0] start_word,
    input  wire logic [15:0] resync_word,
    input  wire logic        q_full,
    output      logic        push,
    output      obfp_cmd_t   push_cmd
);

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_CHECK,
        PH_DATA,
        PH_AFTER
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        half_reg, half_next;
    logic [7:0]  low_reg, low_next;
    logic        drop_reg, drop_next;
    logic [2:0]  slot_reg, slot_next;
    logic [15:0] acc_reg, acc_next;

    logic        accept;
    logic [15:0] word;
    logic [15:0] diff;
    logic        is_start;
    logic        is_resync;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign word        = {in_ch.data_byte, low_reg};
    assign diff        = acc_reg - word;
    assign is_start    = (word == start_word);
    assign is_resync   = (word == resync_word);

    always_comb
    begin
        phase_next    = phase_reg;
        half_next     = half_reg;
        low_next      = low_reg;
        drop_next     = drop_reg;
        slot_next     = slot_reg;
        acc_next      = acc_reg;
        push          = 1'b0;
        push_cmd.op   = OP_FIELD;
        push_cmd.slot = slot_reg[1:0];
        push_cmd.word = word;
        if (accept)
        begin
            if (drop_reg)
            begin
                drop_next = 1'b0;
            end
            else if (!half_reg)
            begin
                low_next  = in_ch.data_byte;
                half_next = 1'b1;
            end
            else
            begin
                half_next = 1'b0;
                case (phase_reg)
                    PH_HUNT2:
                    begin
                        if (is_start)
                        begin
                            phase_next  = PH_CHECK;
                            push        = 1'b1;
                            push_cmd.op = OP_SYNC;
                        end
                        else
                        begin
                            phase_next = PH_HUNT1;
                            drop_next  = is_resync;
                        end
                    end
                    PH_CHECK:
                    begin
                        if (is_start)
                        begin
                            push        = 1'b1;
                            push_cmd.op = OP_FRAME;
                        end
                        else if (word == 16'd0)
                        begin
                            push        = 1'b1;
                            push_cmd.op = OP_NO_DATA;
                            phase_next  = PH_HUNT1;
                        end
                        else
                        begin
                            acc_next   = word;
                            slot_next  = 3'd0;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        acc_next = diff;
                        push     = 1'b1;
                        if (slot_reg < 3'd4)
                        begin
                            push_cmd.op = OP_FIELD;
                            slot_next   = slot_reg + 3'd1;
                        end
                        else
                        begin
                            slot_next = 3'd0;
                            if (diff != 16'd0)
                            begin
                                push_cmd.op = OP_CHECK_ERR;
                                phase_next  = PH_HUNT1;
                            end
                            else
                            begin
                                push_cmd.op = OP_BLOCK;
                                phase_next  = PH_AFTER;
                            end
                        end
                    end
                    PH_AFTER:
                    begin
                        push = 1'b1;
                        if (is_start)
                        begin
                            push_cmd.op = OP_ADVANCE;
                            phase_next  = PH_CHECK;
                        end
                        else
                        begin
                            push_cmd.op = OP_END;
                            phase_next  = PH_HUNT1;
                        end
                    end
                    default:
                    begin
                        if (is_start)
                        begin
                            phase_next = PH_HUNT2;
                        end
                        else
                        begin
                            phase_next = PH_HUNT1;
                            drop_next  = is_resync;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            half_reg  <= 1'b0;
            low_reg   <= 8'd0;
            drop_reg  <= 1'b0;
            slot_reg  <= 3'd0;
            acc_reg   <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            half_reg  <= half_next;
            low_reg   <= low_next;
            drop_reg  <= drop_next;
            slot_reg  <= slot_next;
            acc_reg   <= acc_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/obfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module obfp_queue
    import obfp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire obfp_cmd_t push_cmd,
    input  wire logic      pop,
    output      obfp_cmd_t head_cmd,
    output      logic      full,
    output      logic      empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    obfp_cmd_t       mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign full     = (cnt_reg == CW'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/obfp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module obfp_back
    import obfp_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire obfp_cmd_t head_cmd,
    input  wire logic      empty,
    output      logic      pop,
    obfp_out_if.source     out_ch
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    logic [IW-1:0] index_reg, index_next;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   field_reg [4];

    logic          valid_reg, valid_next;
    logic [2:0]    event_reg, event_next;
    logic [IW-1:0] oidx_reg, oidx_next;
    logic [CW-1:0] ocnt_reg, ocnt_next;
    logic          blk_reg, blk_next;
    logic [15:0]   sig_reg, x_reg, y_reg, w_reg, h_reg;

    logic          emits;
    logic          out_free;
    logic [CW-1:0] inc_count;
    logic [31:0]   oidx_ext;
    logic [31:0]   ocnt_ext;

    assign emits     = !(head_cmd.op == OP_FIELD || head_cmd.op == OP_ADVANCE);
    assign out_free  = !valid_reg || out_ch.ready;
    assign pop       = !empty && (out_free || !emits);
    assign inc_count = CW'({1'b0, index_reg}) + CW'(1);
    assign oidx_ext  = 32'(oidx_reg);
    assign ocnt_ext  = 32'(ocnt_reg);

    always_comb
    begin
        index_next = index_reg;
        count_next = count_reg;
        valid_next = valid_reg && !out_ch.ready;
        event_next = event_reg;
        oidx_next  = oidx_reg;
        ocnt_next  = ocnt_reg;
        blk_next   = blk_reg;
        if (pop)
        begin
            if (emits)
            begin
                valid_next = 1'b1;
                blk_next   = 1'b0;
                oidx_next  = index_reg;
                ocnt_next  = count_reg;
                index_next = '0;
                count_next = '0;
            end
            case (head_cmd.op)
                OP_SYNC:
                begin
                    event_next = EV_SYNC;
                    oidx_next  = '0;
                    ocnt_next  = '0;
                end
                OP_FRAME:
                begin
                    event_next = EV_NEW_FRAME;
                end
                OP_NO_DATA:
                begin
                    event_next = EV_NO_DATA;
                end
                OP_CHECK_ERR:
                begin
                    event_next = EV_CHECK_ERR;
                    ocnt_next  = '0;
                end
                OP_BLOCK:
                begin
                    event_next = EV_BLOCK_OK;
                    blk_next   = 1'b1;
                    ocnt_next  = inc_count;
                    index_next = index_reg;
                    count_next = inc_count;
                end
                OP_END:
                begin
                    event_next = EV_STREAM_END;
                end
                OP_ADVANCE:
                begin
                    index_next = (index_reg == IW'(MAX_BLOCKS - 1)) ? '0 : index_reg + IW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_cmd.op == OP_FIELD)
        begin
            field_reg[head_cmd.slot] <= head_cmd.word;
        end
        if (pop && head_cmd.op == OP_BLOCK)
        begin
            sig_reg <= field_reg[0];
            x_reg   <= field_reg[1];
            y_reg   <= field_reg[2];
            w_reg   <= field_reg[3];
            h_reg   <= head_cmd.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
            event_reg <= EV_SYNC;
            oidx_reg  <= '0;
            ocnt_reg  <= '0;
            blk_reg   <= 1'b0;
        end
        else
        begin
            index_reg <= index_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            event_reg <= event_next;
            oidx_reg  <= oidx_next;
            ocnt_reg  <= ocnt_next;
            blk_reg   <= blk_next;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.event_res   = event_reg;
    assign out_ch.block_index = oidx_ext[2:0];
    assign out_ch.block_count = ocnt_ext[3:0];
    assign out_ch.signature   = blk_reg ? sig_reg : 16'd0;
    assign out_ch.x_pos       = blk_reg ? x_reg : 16'd0;
    assign out_ch.y_pos       = blk_reg ? y_reg : 16'd0;
    assign out_ch.obj_width   = blk_reg ? w_reg : 16'd0;
    assign out_ch.obj_height  = blk_reg ? h_reg : 16'd0;

endmodule
`default_nettype wire

>>> hw/rtl/object_block_frame_parser.sv
// channel   dir  payload                                          handshake
// in_ch     in   data_byte[7:0]                                   valid/ready
// out_ch    out  event_res, block_index, block_count, 5 x 16 bit  valid/ready
// apb       in   start_word @0x0, resync_word @0x4                psel/penable, pready=1
//
// one byte per cycle unless the queue is full; results pass the queue and the output register
// byte pairing, hunting and checksum run in the front stage, counters and fields in the back
// a four-entry command queue between them absorbs output stalls; in_ch.ready drops when full
// rst_n clears all control state and sets both sync words to their defaults
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module object_block_frame_parser
    import obfp_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    obfp_in_if.sink          in_ch,
    obfp_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    logic [15:0] start_reg;
    logic [15:0] resync_reg;
    logic        cfg_wr;

    logic        push;
    obfp_cmd_t   push_cmd;
    obfp_cmd_t   head_cmd;
    logic        pop;
    logic        q_full;
    logic        q_empty;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_RESYNC) ? {16'd0, resync_reg} : {16'd0, start_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= START_WORD_RST;
            resync_reg <= RESYNC_WORD_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_START)
            begin
                start_reg <= pwdata[15:0];
            end
            else
            begin
                resync_reg <= pwdata[15:0];
            end
        end
    end

    obfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .start_word  (start_reg),
        .resync_word (resync_reg),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    obfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    obfp_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .pop      (pop),
        .out_ch   (out_ch)
    );

    `OBFP_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !q_full, "command pushed into full queue")
    `OBFP_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !q_empty, "command popped from empty queue")
    `OBFP_ASSERT_IMPL(a_fields_zero, clk, rst_n, out_ch.valid && out_ch.event_res != EV_BLOCK_OK, out_ch.signature == 16'd0 && out_ch.obj_height == 16'd0, "block words leak into non-block result")
    `OBFP_ASSERT(a_event_range, clk, rst_n, !out_ch.valid || out_ch.event_res <= EV_NEW_FRAME, "event code out of range")

endmodule
`default_nettype wire
